### sv/vrp_pkg.sv
// Shared widths and register indexes for the vertex rotate and project block.
// No dependencies; used by vrp_divider and vertex_rotate_project.
`timescale 1ns / 1ps
package vrp_pkg;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int COEF_W  = 16;
  localparam int DIST_W  = 15;
  localparam int ASP_W   = 15;
  localparam int CFG_IDX_W = 3;

  // Internal coordinate widths after each rotation.
  localparam int Y1_W = 19;
  localparam int X2_W = 22;
  localparam int X3_W = 25;
  localparam int D_W  = 23;

  // Divider widths: numerator magnitude, denominator magnitude, quotient bits.
  localparam int NUM_W = 40;
  localparam int DEN_W = 25;
  localparam int QUO_W = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIST   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT = 3'd7;

endpackage

### sv/vrp_divider.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero
// and saturating to a signed coordinate word. Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_divider #(
  parameter int NW = vrp_pkg::NUM_W,
  parameter int DW = vrp_pkg::DEN_W,
  parameter int QW = vrp_pkg::QUO_W
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [NW-1:0]               num,
  input  logic signed [DW-1:0]               den,
  output logic signed [vrp_pkg::COORD_W-1:0] quo
);

  localparam int CW = DW + QW;
  localparam int OW = vrp_pkg::COORD_W;
  localparam logic [QW-1:0] POS_MAX = QW'((1 << (OW - 1)) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(1 << (OW - 1));

  logic [NW-1:0] rem  [0:QW];
  logic [DW-1:0] dmag [0:QW];
  logic [QW-1:0] qbit [0:QW];
  logic          neg  [0:QW];
  logic          ovf  [0:QW];

  logic [NW-1:0] num_abs;
  logic [DW-1:0] den_abs;

  // Entry stage: magnitudes, result sign and quotient overflow check.
  assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_abs = den[DW-1] ? DW'(-den) : DW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num_abs;
      dmag[0] <= den_abs;
      qbit[0] <= '0;
      neg[0]  <= num[NW-1] ^ den[DW-1];
      ovf[0]  <= CW'(num_abs) >= (CW'(den_abs) << QW);
    end
  end

  // Restoring stages, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [CW-1:0] shifted;
    logic          take;
    assign shifted = CW'(dmag[k-1]) << B;
    assign take    = CW'(rem[k-1]) >= shifted;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? NW'(CW'(rem[k-1]) - shifted) : rem[k-1];
        dmag[k] <= dmag[k-1];
        qbit[k] <= qbit[k-1] | (QW'(take) << B);
        neg[k]  <= neg[k-1];
        ovf[k]  <= ovf[k-1];
      end
    end
  end

  // Apply the sign and clamp to the output range.
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[QW]) begin
        if (ovf[QW] || qbit[QW] > NEG_MAX) begin
          quo <= OW'(NEG_MAX);
        end else begin
          quo <= OW'(-qbit[QW]);
        end
      end else begin
        if (ovf[QW] || qbit[QW] > POS_MAX) begin
          quo <= OW'(POS_MAX);
        end else begin
          quo <= OW'(qbit[QW]);
        end
      end
    end
  end

endmodule

### sv/vertex_rotate_project.sv
// Top level: three rotation stages, numerator setup and two pipelined dividers.
// Depends on vrp_pkg and vrp_divider.
`timescale 1ns / 1ps
// Usage:
// A vertex word (vertex_x/y/z, signed Q4.12) enters on in_valid/in_ready.
// The result word (screen_x/y, signed Q4.12 saturated, zero_depth) leaves
// on out_valid/out_ready. Throughput is one vertex per cycle unless the
// output is held. Four arithmetic stages (X, Y and Z rotation, numerator
// products) feed two dividers that retire one quotient bit per stage
// (17 bits plus an entry and a saturation stage).
// The whole pipeline advances together; when out_valid is high and
// out_ready low it holds every stage and in_ready drops, so no word is
// lost or repeated. Otherwise in_ready stays high even while results flow.
// Configuration writes on cfg_valid/cfg_ready (always ready) set the sine,
// cosine, camera distance and aspect registers; write them only while the
// pipeline is empty. A zero denominator gives zero outputs with zero_depth.
// Reset empties the pipeline and loads identity rotation, distance 5.0
// and aspect 0.75.
module vertex_rotate_project (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vertex_x,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vertex_y,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vertex_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vrp_pkg::COORD_W-1:0]    screen_x,
  output logic signed [vrp_pkg::COORD_W-1:0]    screen_y,
  output logic                                  zero_depth,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vrp_pkg::COEF_W-1:0]            cfg_data
);

  localparam int DLAT = vrp_pkg::QUO_W + 2;
  localparam int CW   = vrp_pkg::COEF_W;

  // Configuration registers.
  logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
  logic [vrp_pkg::DIST_W-1:0] cam_dist;
  logic [vrp_pkg::ASP_W-1:0]  asp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= CW'(16384);
      sx       <= '0;
      cy       <= CW'(16384);
      sy       <= '0;
      cz       <= CW'(16384);
      sz       <= '0;
      cam_dist <= vrp_pkg::DIST_W'(20480);
      asp      <= vrp_pkg::ASP_W'(12288);
    end else if (cfg_valid) begin
      case (cfg_index)
        vrp_pkg::REG_COS_X:  cx       <= cfg_data;
        vrp_pkg::REG_SIN_X:  sx       <= cfg_data;
        vrp_pkg::REG_COS_Y:  cy       <= cfg_data;
        vrp_pkg::REG_SIN_Y:  sy       <= cfg_data;
        vrp_pkg::REG_COS_Z:  cz       <= cfg_data;
        vrp_pkg::REG_SIN_Z:  sz       <= cfg_data;
        vrp_pkg::REG_DIST:   cam_dist <= cfg_data[vrp_pkg::DIST_W-1:0];
        vrp_pkg::REG_ASPECT: asp      <= cfg_data[vrp_pkg::ASP_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a finished word is held.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic v1, v2, v3, v4;

  // Stage 1: rotate about X.
  logic signed [32:0] s1y, s1z;
  logic signed [vrp_pkg::Y1_W-1:0]   y1, z1;
  logic signed [vrp_pkg::COORD_W-1:0] x1;
  assign s1y = vertex_y * cx - vertex_z * sx + 33'sd8192;
  assign s1z = vertex_y * sx + vertex_z * cx + 33'sd8192;

  always_ff @(posedge clk) begin
    if (adv) begin
      y1 <= s1y[32:14];
      z1 <= s1z[32:14];
      x1 <= vertex_x;
    end
  end

  // Stage 2: rotate about Y.
  logic signed [35:0] s2x, s2z;
  logic signed [vrp_pkg::X2_W-1:0] x2, z2;
  logic signed [vrp_pkg::Y1_W-1:0] y2;
  assign s2x = x1 * cy + z1 * sy + 36'sd8192;
  assign s2z = z1 * cy - x1 * sy + 36'sd8192;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2 <= s2x[35:14];
      z2 <= s2z[35:14];
      y2 <= y1;
    end
  end

  // Stage 3: rotate about Z and form the depth.
  logic signed [38:0] s3x, s3y;
  logic signed [vrp_pkg::X3_W-1:0] x3, y3;
  logic signed [vrp_pkg::D_W-1:0]  d3;
  assign s3x = x2 * cz - y2 * sz + 39'sd8192;
  assign s3y = x2 * sz + y2 * cz + 39'sd8192;

  always_ff @(posedge clk) begin
    if (adv) begin
      x3 <= s3x[38:14];
      y3 <= s3y[38:14];
      d3 <= z2 + $signed({1'b0, cam_dist});
    end
  end

  // Stage 4: numerators and denominators for both quotients.
  logic signed [vrp_pkg::NUM_W-1:0] nx4, ny4;
  logic signed [vrp_pkg::DEN_W-1:0] dx4, dy4;
  logic                             z4;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx4 <= x3 * $signed({1'b0, asp});
      ny4 <= {{(vrp_pkg::NUM_W - vrp_pkg::X3_W - 12){y3[vrp_pkg::X3_W-1]}}, y3, 12'd0};
      dx4 <= {d3, 2'b00};
      dy4 <= vrp_pkg::DEN_W'(d3);
      z4  <= (d3 == '0);
    end
  end

  // Valid bits for the arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Dividers.
  logic signed [vrp_pkg::COORD_W-1:0] qx, qy;

  vrp_divider #(
    .NW(vrp_pkg::NUM_W), .DW(vrp_pkg::DEN_W), .QW(vrp_pkg::QUO_W)
  ) u_div_x (
    .clk(clk), .en(adv), .num(nx4), .den(dx4), .quo(qx)
  );

  vrp_divider #(
    .NW(vrp_pkg::NUM_W), .DW(vrp_pkg::DEN_W), .QW(vrp_pkg::QUO_W)
  ) u_div_y (
    .clk(clk), .en(adv), .num(ny4), .den(dy4), .quo(qy)
  );

  // Valid and zero-depth flags travel beside the divider stages.
  logic dv [0:DLAT-1];
  logic dz [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLAT; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (adv) begin
      dv[0] <= v4;
      for (int i = 1; i < DLAT; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz[0] <= z4;
      for (int i = 1; i < DLAT; i++) begin
        dz[i] <= dz[i-1];
      end
    end
  end

  // Output word.
  assign out_valid  = dv[DLAT-1];
  assign zero_depth = dz[DLAT-1];
  assign screen_x   = dz[DLAT-1] ? '0 : qx;
  assign screen_y   = dz[DLAT-1] ? '0 : qy;

  // A zero denominator always yields zero coordinates.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_depth |-> screen_x == '0 && screen_y == '0)
    else $error("zero depth with nonzero coordinates");

  // A held output freezes the stage 4 and first divider valid bits and keeps out_valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(v4) && $stable(dv[0]) && out_valid)
    else $error("pipeline moved during stall");

  // Reset leaves the pipeline empty.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v4)
    else $error("pipeline not empty after reset");

  // Input is refused only while a finished word is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

endmodule

### verif/vrp_checker.sv
// Checker for vertex_rotate_project: watches the vertex, result and register
// channels, predicts each result word and compares it. Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [vrp_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [vrp_pkg::COORD_W-1:0] vertex_y,
  input  logic signed [vrp_pkg::COORD_W-1:0] vertex_z,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [vrp_pkg::COORD_W-1:0] screen_x,
  input  logic signed [vrp_pkg::COORD_W-1:0] screen_y,
  input  logic                               zero_depth,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrp_pkg::COEF_W-1:0]         cfg_data,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               zd;
  } screen_word_t;

  // Shadow copy of the coefficient registers.
  logic signed [15:0] coef [0:5];
  logic [14:0] dist_reg;
  logic [14:0] aspect_reg;

  screen_word_t projected_q[$];

  // Round half up and drop 14 fraction bits.
  function automatic longint q14_round(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic screen_word_t project_vertex(longint x, longint y, longint z);
    longint y1, z1, x2, z2, x3, y3, d;
    screen_word_t w;
    y1 = q14_round(y * coef[vrp_pkg::REG_COS_X] - z * coef[vrp_pkg::REG_SIN_X]);
    z1 = q14_round(y * coef[vrp_pkg::REG_SIN_X] + z * coef[vrp_pkg::REG_COS_X]);
    x2 = q14_round(x * coef[vrp_pkg::REG_COS_Y] + z1 * coef[vrp_pkg::REG_SIN_Y]);
    z2 = q14_round(z1 * coef[vrp_pkg::REG_COS_Y] - x * coef[vrp_pkg::REG_SIN_Y]);
    x3 = q14_round(x2 * coef[vrp_pkg::REG_COS_Z] - y1 * coef[vrp_pkg::REG_SIN_Z]);
    y3 = q14_round(x2 * coef[vrp_pkg::REG_SIN_Z] + y1 * coef[vrp_pkg::REG_COS_Z]);
    d = z2 + longint'(dist_reg);
    if (d == 0) begin
      w.sx = '0; w.sy = '0; w.zd = 1'b1;
    end else begin
      w.sx = 16'(clamp16((x3 * longint'(aspect_reg)) / (d * 4)));
      w.sy = 16'(clamp16((y3 * 4096) / d));
      w.zd = 1'b0;
    end
    return w;
  endfunction

  assign pending_count = projected_q.size();

  // Track register writes, predict on each accepted vertex, check results.
  always @(posedge clk) begin
    screen_word_t exp_w;
    if (rst) begin
      coef[vrp_pkg::REG_COS_X] <= 16'sd16384; coef[vrp_pkg::REG_SIN_X] <= '0;
      coef[vrp_pkg::REG_COS_Y] <= 16'sd16384; coef[vrp_pkg::REG_SIN_Y] <= '0;
      coef[vrp_pkg::REG_COS_Z] <= 16'sd16384; coef[vrp_pkg::REG_SIN_Z] <= '0;
      dist_reg <= 15'd20480;
      aspect_reg <= 15'd12288;
      projected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vrp_pkg::REG_DIST:   dist_reg <= cfg_data[14:0];
          vrp_pkg::REG_ASPECT: aspect_reg <= cfg_data[14:0];
          default:             coef[cfg_index] <= cfg_data;
        endcase
      end
      if (in_valid && in_ready)
        projected_q = {projected_q, project_vertex(vertex_x, vertex_y, vertex_z)};
      if (out_valid && out_ready) begin
        if (projected_q.size() == 0) begin
          $error("unexpected result word sx=%0d sy=%0d", screen_x, screen_y);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = projected_q.pop_front();
          if (screen_x !== exp_w.sx || screen_y !== exp_w.sy || zero_depth !== exp_w.zd)
            fail_count <= fail_count + 1;
          if (screen_x !== exp_w.sx)
            $error("screen_x expected %0d got %0d", exp_w.sx, screen_x);
          if (screen_y !== exp_w.sy)
            $error("screen_y expected %0d got %0d", exp_w.sy, screen_y);
          if (zero_depth !== exp_w.zd)
            $error("zero_depth expected %0d got %0d", exp_w.zd, zero_depth);
        end
      end
    end
  end
endmodule

### verif/vertex_rotate_project_tb.sv
// Testbench top for vertex_rotate_project: drives vertex words and register
// writes, stalls both sides at random, and reports the verdict from vrp_checker.
`timescale 1ns / 1ps
module vertex_rotate_project_tb;

  localparam int PIPE_LAT = 23;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, zero_depth;
  logic signed [15:0] vertex_x, vertex_y, vertex_z, screen_x, screen_y;
  logic cfg_valid, cfg_ready;
  logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending_count;
  int send_idle_pct, stall_pct;

  vertex_rotate_project dut (.*);

  vrp_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("vertex_rotate_project_tb: done, errors");
    $finish;
  end

  // Receiver stalls at random with the current phase's rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Valid stays high after the write; the next send_vertex or drain drops it.
  task automatic write_reg(logic [vrp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Valid drops only during idle cycles, so back to back words never see
  // two assignments to in_valid at one edge.
  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; vertex_x <= x; vertex_y <= y; vertex_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every result has come, then let the pipeline drain.
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_setting(int kind);
    for (int r = 0; r < 6; r++) write_reg(r[2:0], pick_coef());
    case (kind)
      0: begin
        write_reg(vrp_pkg::REG_DIST, 16'd0);
        write_reg(vrp_pkg::REG_ASPECT, 16'd0);
      end
      1: begin
        write_reg(vrp_pkg::REG_DIST, 16'h7FFF);
        write_reg(vrp_pkg::REG_ASPECT, 16'h7FFF);
      end
      default: begin
        write_reg(vrp_pkg::REG_DIST, 16'($urandom_range(32767)));
        write_reg(vrp_pkg::REG_ASPECT, 16'($urandom_range(16384)));
      end
    endcase
  endtask

  initial begin
    in_valid = 0; vertex_x = 0; vertex_y = 0; vertex_z = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    send_idle_pct = 0; stall_pct = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed words at reset settings: extremes, zero depth, negative depth.
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7FFF, 16'h8000, 16'hB000);
    send_vertex(16'h1000, 16'h2000, 16'hB000);
    send_vertex(16'h4000, 16'hC000, 16'hA000);
    send_vertex(16'h8000, 16'h7FFF, 16'hAFFF);
    drain();
    // Rotation about X moves y into the depth; then coefficients beyond one.
    write_reg(vrp_pkg::REG_SIN_X, 16'sd16384); write_reg(vrp_pkg::REG_COS_X, 16'd0);
    write_reg(vrp_pkg::REG_DIST, 16'd4096);
    send_vertex(16'h1234, 16'h1000, 16'h0777);
    send_vertex(16'h8000, 16'h7FFF, 16'h0000);
    drain();
    write_reg(vrp_pkg::REG_ASPECT, 16'h7FFF);
    write_reg(vrp_pkg::REG_COS_Y, 16'h7FFF); write_reg(vrp_pkg::REG_SIN_Y, 16'h8000);
    write_reg(vrp_pkg::REG_COS_Z, 16'h8000); write_reg(vrp_pkg::REG_SIN_Z, 16'h7FFF);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(16'h0001, 16'hFFFF, 16'h0001);
    drain();

    // Random phases cycling through idling modes and register settings.
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      random_setting(ph % 3);
      for (int n = 0; n < 50; n++) begin
        // Coordinates come from the extremes, a range near zero or the full random range.
        send_vertex(pick_coord(), pick_coord(), pick_coord());
      end
      drain();
    end
    // Identity rotation with depth cancelling the distance.
    stall_pct = 0;
    write_reg(vrp_pkg::REG_COS_X, 16'sd16384); write_reg(vrp_pkg::REG_SIN_X, 16'd0);
    write_reg(vrp_pkg::REG_COS_Y, 16'sd16384); write_reg(vrp_pkg::REG_SIN_Y, 16'd0);
    write_reg(vrp_pkg::REG_COS_Z, 16'sd16384); write_reg(vrp_pkg::REG_SIN_Z, 16'd0);
    write_reg(vrp_pkg::REG_DIST, 16'd8192);
    for (int n = 0; n < 10; n++) send_vertex(16'($urandom), 16'($urandom), 16'hE000);
    drain();

    if (fail_count == 0)
      $display("vertex_rotate_project_tb: done, clean");
    else
      $display("vertex_rotate_project_tb: done, errors");
    $finish;
  end
endmodule
